[hdl/nal_unit_escape_packer_assert.svh]
// Assertion macros used by the checker file of the escape packer.
// Each macro samples on the rising edge of clk and is disabled while
// arst_n is low.
`ifndef NAL_UNIT_ESCAPE_PACKER_ASSERT_SVH
`define NAL_UNIT_ESCAPE_PACKER_ASSERT_SVH

// Same-cycle implication.
`define NUEP_ASSERT_SAME(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("escape packer: same-cycle check failed");

// Next-cycle implication.
`define NUEP_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("escape packer: next-cycle check failed");

`endif

[hdl/nuep_pkg.sv]
package nuep_pkg;

	// Items held between the front and the back end
	localparam int QueueDepth = 4;

	localparam logic [7:0] ByteZero      = 8'h00;
	localparam logic [7:0] StartCodeTail = 8'h01;
	localparam logic [7:0] EscapeByte    = 8'h03;

	// Zero run length at which a small byte must be escaped
	localparam logic [1:0] RunEscape = 2'd2;

	// Classified payload byte, as queued for the back end
	typedef struct packed {
		logic [7:0] data;
		logic       last;
		logic       prefix;
		logic       esc;
		logic       trail;
	} unit_item_t;

endpackage

[hdl/nuep_front.sv]
module nuep_front (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 push,
	input  logic [7:0]           payload_byte,
	input  logic                 payload_last,
	input  logic                 q_full,
	output logic                 wr,
	output nuep_pkg::unit_item_t desc
);
	import nuep_pkg::*;

	logic [1:0] zero_run_q;
	logic       unit_open_q;
	logic       esc;
	logic       is_zero;
	logic [1:0] run_base;
	logic [1:0] run_next;

	// Classify the incoming item against the running zero count
	assign wr       = push && !q_full;
	assign is_zero  = (payload_byte == ByteZero);
	assign esc      = (zero_run_q == RunEscape) && (payload_byte <= EscapeByte);
	assign run_base = esc ? 2'd0 : zero_run_q;
	always_comb begin
		if (!is_zero) begin
			run_next = 2'd0;
		end else if (run_base == RunEscape) begin
			run_next = RunEscape;
		end else begin
			run_next = run_base + 2'd1;
		end
	end

	assign desc.data   = payload_byte;
	assign desc.last   = payload_last;
	assign desc.prefix = !unit_open_q;
	assign desc.esc    = esc;
	assign desc.trail  = payload_last && is_zero;

	// Advance the unit state on each accepted item; close it on the last byte
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			zero_run_q  <= 2'd0;
			unit_open_q <= 1'b0;
		end else if (wr) begin
			if (payload_last) begin
				zero_run_q  <= 2'd0;
				unit_open_q <= 1'b0;
			end else begin
				zero_run_q  <= run_next;
				unit_open_q <= 1'b1;
			end
		end
	end

endmodule

[hdl/nuep_queue.sv]
module nuep_queue #(
	parameter int DEPTH = nuep_pkg::QueueDepth
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 wr,
	input  nuep_pkg::unit_item_t wr_data,
	input  logic                 rd,
	output nuep_pkg::unit_item_t rd_data,
	output logic                 full,
	output logic                 empty
);
	import nuep_pkg::*;

	localparam int PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CntW = $clog2(DEPTH + 1);
	localparam logic [PtrW-1:0] PtrLast = PtrW'(DEPTH - 1);
	localparam logic [CntW-1:0] CntFull = CntW'(DEPTH);

	unit_item_t      mem_q [DEPTH];
	logic [PtrW-1:0] wr_ptr_q;
	logic [PtrW-1:0] rd_ptr_q;
	logic [CntW-1:0] count_q;
	logic            do_wr;
	logic            do_rd;

	assign full    = (count_q == CntFull);
	assign empty   = (count_q == '0);
	assign do_wr   = wr && !full;
	assign do_rd   = rd && !empty;
	assign rd_data = mem_q[rd_ptr_q];

	// Hold queued items
	always_ff @(posedge clk) begin
		if (do_wr) begin
			mem_q[wr_ptr_q] <= wr_data;
		end
	end

	// Advance pointers and occupancy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_wr) begin
				wr_ptr_q <= (wr_ptr_q == PtrLast) ? '0 : wr_ptr_q + PtrW'(1);
			end
			if (do_rd) begin
				rd_ptr_q <= (rd_ptr_q == PtrLast) ? '0 : rd_ptr_q + PtrW'(1);
			end
			if (do_wr && !do_rd) begin
				count_q <= count_q + CntW'(1);
			end else if (do_rd && !do_wr) begin
				count_q <= count_q - CntW'(1);
			end
		end
	end

endmodule

[hdl/nuep_back.sv]
module nuep_back (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 q_empty,
	input  nuep_pkg::unit_item_t q_head,
	output logic                 q_pop,
	input  logic                 pop,
	output logic                 empty,
	output logic [7:0]           out_byte,
	output logic                 out_last
);
	import nuep_pkg::*;

	typedef enum logic [7:0] {
		ST_IDLE  = 8'b0000_0001,
		ST_SC0   = 8'b0000_0010,
		ST_SC1   = 8'b0000_0100,
		ST_SC2   = 8'b0000_1000,
		ST_SC3   = 8'b0001_0000,
		ST_ESC   = 8'b0010_0000,
		ST_DATA  = 8'b0100_0000,
		ST_TRAIL = 8'b1000_0000
	} back_state_t;

	function automatic back_state_t entry_state(input unit_item_t it);
		if (it.prefix) begin
			entry_state = ST_SC0;
		end else if (it.esc) begin
			entry_state = ST_ESC;
		end else begin
			entry_state = ST_DATA;
		end
	endfunction

	back_state_t state_q;
	back_state_t state_d;
	unit_item_t  cur_q;
	logic        adv;
	logic        item_done;

	assign empty = (state_q == ST_IDLE);
	assign adv   = pop && !empty;

	// Drive the byte for the current step
	always_comb begin
		out_last = 1'b0;
		case (state_q)
			ST_SC0, ST_SC1, ST_SC2: out_byte = ByteZero;
			ST_SC3:                 out_byte = StartCodeTail;
			ST_ESC:                 out_byte = EscapeByte;
			ST_DATA: begin
				out_byte = cur_q.data;
				out_last = cur_q.last && !cur_q.trail;
			end
			ST_TRAIL: begin
				out_byte = EscapeByte;
				out_last = 1'b1;
			end
			default:                out_byte = ByteZero;
		endcase
	end

	// Step through the item; take the next one as soon as this one finishes
	always_comb begin
		state_d   = state_q;
		item_done = 1'b0;
		q_pop     = 1'b0;
		case (state_q)
			ST_IDLE:  item_done = 1'b1;
			ST_SC0:   if (adv) state_d = ST_SC1;
			ST_SC1:   if (adv) state_d = ST_SC2;
			ST_SC2:   if (adv) state_d = ST_SC3;
			ST_SC3:   if (adv) state_d = cur_q.esc ? ST_ESC : ST_DATA;
			ST_ESC:   if (adv) state_d = ST_DATA;
			ST_DATA: begin
				if (adv) begin
					if (cur_q.trail) begin
						state_d = ST_TRAIL;
					end else begin
						item_done = 1'b1;
					end
				end
			end
			ST_TRAIL: item_done = adv;
			default:  state_d = ST_IDLE;
		endcase
		if (item_done) begin
			if (!q_empty) begin
				q_pop   = 1'b1;
				state_d = entry_state(q_head);
			end else begin
				state_d = ST_IDLE;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Load the item being emitted
	always_ff @(posedge clk) begin
		if (q_pop) begin
			cur_q <= q_head;
		end
	end

endmodule

[hdl/nal_unit_escape_packer.sv]
// Annex B framer with emulation prevention for one coding unit at a time.
// Input queue port: payload_byte/payload_last, taken when push is high and
// full is low; payload_last marks the final byte of a unit.
// Output queue port: out_byte/out_last, valid while empty is low, taken when
// pop is high; out_last marks the final byte of the framed unit.
// Each unit opens with 00 00 00 01; 03 is inserted before any byte of 03 or
// less that follows two zeros, and a unit ending in zero gets a trailing 03.
// One input item yields one to six output bytes.
// With the output side idle, an accepted item is written into the item queue
// and then loaded into the back-end registers, which show its first byte.
// Throughput: one output byte per cycle while pop is high, set by the back-end
// sequencer; input runs at one item per cycle while items make one byte each,
// and the QUEUE_DEPTH-entry item queue absorbs start codes and escapes.
// When pop stays low the shown byte holds, the queue fills and full rises.
// Reset clears the queue and the zero count; the next byte opens a new unit.
module nal_unit_escape_packer #(
	parameter int QUEUE_DEPTH = nuep_pkg::QueueDepth
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       push,
	output logic       full,
	input  logic [7:0] payload_byte,
	input  logic       payload_last,
	output logic       empty,
	input  logic       pop,
	output logic [7:0] out_byte,
	output logic       out_last
);
	import nuep_pkg::*;

	unit_item_t wr_item;
	unit_item_t head_item;
	logic       wr;
	logic       q_pop;
	logic       q_empty;

	// Classify items and track the zero run
	nuep_front u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.push         (push),
		.payload_byte (payload_byte),
		.payload_last (payload_last),
		.q_full       (full),
		.wr           (wr),
		.desc         (wr_item)
	);

	// Decouple acceptance from emission
	nuep_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr      (wr),
		.wr_data (wr_item),
		.rd      (q_pop),
		.rd_data (head_item),
		.full    (full),
		.empty   (q_empty)
	);

	// Emit start code, escape, payload and trailing bytes
	nuep_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.q_empty  (q_empty),
		.q_head   (head_item),
		.q_pop    (q_pop),
		.pop      (pop),
		.empty    (empty),
		.out_byte (out_byte),
		.out_last (out_last)
	);

endmodule

[hdl/nuep_checker.sv]
`include "nal_unit_escape_packer_assert.svh"

module nuep_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       push,
	input logic       full,
	input logic [7:0] payload_byte,
	input logic       payload_last,
	input logic       empty,
	input logic       pop,
	input logic [7:0] out_byte,
	input logic       out_last
);

	// A stalled item holds its value
	`NUEP_ASSERT_NEXT(a_out_hold, !empty && !pop, !empty && $stable(out_byte) && $stable(out_last))

	// A unit never ends on a zero byte
	`NUEP_ASSERT_SAME(a_last_nonzero, !empty && out_last, out_byte != 8'h00)

	// The byte after a unit's end opens a start code
	`NUEP_ASSERT_NEXT(a_unit_restart, pop && !empty && out_last, empty || out_byte == 8'h00)

	// Once an accepted item has passed the queue and the back-end registers, the output side is not empty
	`NUEP_ASSERT_NEXT(a_item_shows, push && !full, ##1 !empty)

endmodule

bind nal_unit_escape_packer nuep_checker u_nuep_checker (.*);

[sim/nal_unit_escape_packer_test.sv]
`timescale 1ns / 1ps

module nal_unit_escape_packer_test;
	import nuep_pkg::*;

	// One byte with its end-of-unit flag, on either side of the block
	typedef struct packed {
		logic [7:0] data;
		logic       last;
	} unit_beat_t;

	localparam int RandomItems   = 400;
	localparam int TailItems     = 40;
	localparam int HoldAfter     = 120;
	localparam int HoldCycles    = 300;
	localparam int WatchdogLimit = 2000;
	localparam int DrainCycles   = 20;
	localparam int ReportLimit   = 10;

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       push = 1'b0;
	logic       pop = 1'b0;
	logic [7:0] payload_byte = 8'h00;
	logic       payload_last = 1'b0;
	logic       full;
	logic       empty;
	logic [7:0] out_byte;
	logic       out_last;

	unit_beat_t payload_queue[$];
	unit_beat_t framed_due[$];
	unit_beat_t send_now;
	unit_beat_t want;

	// Predictor state
	logic [1:0] zero_run = 2'd0;
	logic       unit_open = 1'b0;

	int total_items = 0;
	int accepted_items = 0;
	int mismatches = 0;
	int send_gap = 0;
	int stall_left = 0;
	int hold_left = 0;
	bit hold_done = 1'b0;
	int quiet_cycles = 0;

	nal_unit_escape_packer uut (
		.clk          (clk),
		.arst_n       (arst_n),
		.push         (push),
		.full         (full),
		.payload_byte (payload_byte),
		.payload_last (payload_last),
		.empty        (empty),
		.pop          (pop),
		.out_byte     (out_byte),
		.out_last     (out_last)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	// Queue one unit, first byte in the top of seq, last flag on the final byte
	task automatic add_unit(input logic [63:0] seq, input int n);
		for (int i = n - 1; i >= 0; i--) begin
			payload_queue.push_back('{data: seq[8*i +: 8], last: (i == 0)});
		end
	endtask

	// Work out the framed bytes that one accepted payload byte produces
	task automatic predict_framing(input logic [7:0] b, input logic last);
		unit_beat_t frame[$];
		if (!unit_open) begin
			for (int i = 0; i < 3; i++)
				frame.push_back('{data: ByteZero, last: 1'b0});
			frame.push_back('{data: StartCodeTail, last: 1'b0});
			unit_open = 1'b1;
			zero_run = 2'd0;
		end
		if (zero_run >= RunEscape && b <= EscapeByte) begin
			frame.push_back('{data: EscapeByte, last: 1'b0});
			zero_run = 2'd0;
		end
		frame.push_back('{data: b, last: 1'b0});
		if (b == ByteZero) begin
			if (zero_run < RunEscape)
				zero_run = zero_run + 2'd1;
		end else begin
			zero_run = 2'd0;
		end
		if (last) begin
			if (b == ByteZero)
				frame.push_back('{data: EscapeByte, last: 1'b0});
			frame[frame.size() - 1].last = 1'b1;
			zero_run = 2'd0;
			unit_open = 1'b0;
		end
		foreach (frame[i])
			framed_due.push_back(frame[i]);
	endtask

	// Sender: offer queued items, idling in random bursts until the tail
	always @(posedge clk) begin
		if (arst_n && (!push || !full)) begin
			if (send_gap > 0) begin
				send_gap--;
				push <= 1'b0;
			end else if (payload_queue.size() == 0) begin
				push <= 1'b0;
			end else if (payload_queue.size() > TailItems && $urandom_range(0, 11) == 0) begin
				send_gap = $urandom_range(0, 16);
				push <= 1'b0;
			end else begin
				send_now = payload_queue.pop_front();
				payload_byte <= send_now.data;
				payload_last <= send_now.last;
				push <= 1'b1;
			end
		end
	end

	// Receiver: check each taken byte, predict from each taken item, steer pop
	always @(posedge clk) begin
		if (arst_n) begin
			if (pop && !empty) begin
				if (framed_due.size() == 0) begin
					mismatches++;
					if (mismatches <= ReportLimit)
						$display("unexpected output: byte %02h last %0b", out_byte, out_last);
				end else begin
					want = framed_due.pop_front();
					if (out_byte !== want.data || out_last !== want.last) begin
						mismatches++;
						if (mismatches <= ReportLimit)
							$display("mismatch: expected byte %02h last %0b, got byte %02h last %0b",
								want.data, want.last, out_byte, out_last);
					end
				end
			end

			if (push && !full) begin
				predict_framing(payload_byte, payload_last);
				accepted_items++;
			end

			// Hold off once for a long stretch so that the input side backs up
			if (hold_left > 0) begin
				hold_left--;
				pop <= 1'b0;
			end else if (!hold_done && accepted_items >= HoldAfter) begin
				hold_done = 1'b1;
				hold_left = HoldCycles - 1;
				pop <= 1'b0;
			end else if (stall_left > 0) begin
				stall_left--;
				pop <= 1'b0;
			end else if (accepted_items < total_items - TailItems && $urandom_range(0, 9) == 0) begin
				stall_left = $urandom_range(0, 16);
				pop <= 1'b0;
			end else begin
				pop <= 1'b1;
			end
		end
	end

	// Abort when neither side moves for too long
	always @(posedge clk) begin
		if (arst_n) begin
			if ((push && !full) || (pop && !empty))
				quiet_cycles = 0;
			else
				quiet_cycles++;
			if (quiet_cycles >= WatchdogLimit) begin
				$display("nal_unit_escape_packer verification failed");
				$finish;
			end
		end
	end

	initial begin
		int         len;
		int         pick;
		int         directed;
		logic [7:0] b;

		// Directed units: one-byte units, escapes of every small value,
		// escaped zero feeding the next run, trailing zero after an escape
		add_unit(64'h00, 1);
		add_unit(64'hff, 1);
		add_unit(64'h00_00_00, 3);
		add_unit(64'h00_00_01_00_00_02, 6);
		add_unit(64'h00_00_03_00_00_04, 6);
		add_unit(64'h00_00_00_00_01, 5);
		add_unit(64'h80_7f_55_aa_01, 5);
		directed = payload_queue.size();

		// Random units, heavy on zeros and small bytes
		while (payload_queue.size() < directed + RandomItems) begin
			len = ($urandom_range(0, 7) == 0) ? $urandom_range(13, 40) : $urandom_range(1, 12);
			for (int i = 0; i < len; i++) begin
				pick = $urandom_range(0, 9);
				if (pick < 4)
					b = ByteZero;
				else if (pick < 6)
					b = 8'($urandom_range(1, EscapeByte));
				else if (pick == 6)
					b = EscapeByte + 8'd1;
				else
					b = 8'($urandom_range(0, 255));
				payload_queue.push_back('{data: b, last: (i == len - 1)});
			end
		end
		total_items = payload_queue.size();

		repeat (10) @(posedge clk);
		arst_n <= 1'b1;

		// Drain: all items in, all bytes out, then an idle wait before the verdict
		while (accepted_items < total_items)
			@(posedge clk);
		while (framed_due.size() > 0)
			@(posedge clk);
		repeat (DrainCycles) @(posedge clk);

		if (mismatches == 0)
			$display("nal_unit_escape_packer verification clean");
		else
			$display("nal_unit_escape_packer verification failed");
		$finish;
	end

endmodule
